@@ sv/aps_pkg.sv @@
// Shared types and constants for the all-to-all peer schedule block.
// No dependencies; every other file imports this package.
package aps_pkg;

    localparam int MAX_RANKS  = 1024;
    localparam int MAX_DIGITS = 10;
    localparam int CFG_W      = 11;
    localparam int RANK_W     = 10;
    localparam int IDX_W      = 4;
    localparam int DIV_STEPS  = CFG_W;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_GROUP_SIZE = 2'd0;
    localparam logic [1:0] REG_OWN_RANK   = 2'd1;
    localparam logic [1:0] REG_SCHED_MODE = 2'd2;

    // Schedule modes
    localparam logic [1:0] MODE_XOR = 2'd0;
    localparam logic [1:0] MODE_LIN = 2'd1;
    localparam logic [1:0] MODE_MIX = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_XOR_SKIP = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic fact_init;
        logic fact_div;
        logic fact_push_d;
        logic fact_inc;
        logic fact_close;
        logic digit_init;
        logic digit_div;
        logic digit_comb;
        logic digit_acc;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic range_err;
        logic mode_mix;
        logic bases_ready;
        logic div_busy;
        logic fn_le1;
        logic rem_zero;
        logic sq_gt;
        logic digits_done;
        logic out_busy;
    } t_stat;

endpackage

@@ sv/aps_datapath.sv @@
// Datapath: configuration registers, factor table, shared two-lane divider,
// digit accumulators and the output register. Depends on aps_pkg.
module aps_datapath import aps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [RANK_W-1:0] i_step_index,
    input  logic              i_ready,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic [RANK_W-1:0] o_dest_rank,
    output logic [RANK_W-1:0] o_src_rank,
    output logic [1:0]        o_status
);

    logic [CFG_W-1:0]  r_gs;
    logic [RANK_W-1:0] r_own;
    logic [1:0]        r_mode;
    logic              r_ready_tab;
    logic [IDX_W-1:0]  r_cnt;
    logic [CFG_W-1:0]  r_bases [MAX_DIGITS];
    logic [RANK_W-1:0] r_step;

    logic [CFG_W-1:0]  r_fn, r_fd;
    logic [CFG_W-1:0]  r_dq_a, r_dr_a, r_dq_b, r_dr_b, r_dvs;
    logic              r_dbusy;
    logic [IDX_W-1:0]  r_dcnt;

    logic [CFG_W-1:0]  r_tr, r_ts, r_sa, r_ss, r_w, r_pa, r_ps;
    logic [IDX_W-1:0]  r_k;

    logic              r_ov;
    logic [RANK_W-1:0] r_sp, r_rp;
    logic [1:0]        r_st;

    logic [CFG_W:0]    t_a, t_b, dvs_x;
    logic              ge_a, ge_b;
    logic [CFG_W:0]    fd_inc;
    logic [2*CFG_W+1:0] sq;
    logic [IDX_W-1:0]  base_idx;
    logic [CFG_W:0]    dsum, dsub;
    logic [CFG_W-1:0]  dd_a, dd_s;
    logic [2*CFG_W-1:0] prod_a, prod_s, prod_w;
    logic              range_err, pow2;
    logic [CFG_W:0]    lin_s, lin_r;
    logic [RANK_W-1:0] n_sp, n_rp;
    logic [1:0]        n_st;

    // Range check on the captured step and power-of-two test on the group size
    assign range_err = (r_gs == '0) || (r_gs > CFG_W'(MAX_RANKS))
                     || ({1'b0, r_step} >= r_gs) || ({1'b0, r_own} >= r_gs);
    assign pow2 = ((r_gs & (r_gs - CFG_W'(1))) == '0);

    // Divider iteration, one quotient bit per cycle on both lanes
    assign dvs_x = {1'b0, r_dvs};
    assign t_a   = {r_dr_a, r_dq_a[CFG_W-1]};
    assign t_b   = {r_dr_b, r_dq_b[CFG_W-1]};
    assign ge_a  = (t_a >= dvs_x);
    assign ge_b  = (t_b >= dvs_x);

    // Trial divisor square test for the next candidate
    assign fd_inc = {1'b0, r_fd} + (CFG_W+1)'(1);
    assign sq     = fd_inc * fd_inc;

    // Digit bases are stored smallest first; walk them largest first
    assign base_idx = r_cnt - IDX_W'(1) - r_k;

    // Digit-wise add and subtract modulo the current base
    assign dsum = {1'b0, r_dr_a} + {1'b0, r_dr_b};
    assign dsub = {1'b0, r_dr_a} + dvs_x - {1'b0, r_dr_b};
    assign dd_a = (dsum >= dvs_x) ? CFG_W'(dsum - dvs_x) : dsum[CFG_W-1:0];
    assign dd_s = (r_dr_a >= r_dr_b) ? (r_dr_a - r_dr_b) : dsub[CFG_W-1:0];
    assign prod_a = dd_a * r_w;
    assign prod_s = dd_s * r_w;
    assign prod_w = r_w * r_dvs;

    // Linear rotation
    always_comb begin
        lin_s = {2'b0, r_own} + {2'b0, r_step};
        if (lin_s >= {1'b0, r_gs}) begin
            lin_s = lin_s - {1'b0, r_gs};
        end
        if (r_own >= r_step) begin
            lin_r = {2'b0, r_own - r_step};
        end else begin
            lin_r = {2'b0, r_own} + {1'b0, r_gs} - {2'b0, r_step};
        end
    end

    // Select the result by mode
    always_comb begin
        n_sp = '0;
        n_rp = '0;
        n_st = ST_OK;
        if (range_err) begin
            n_st = ST_RANGE;
        end else begin
            case (r_mode)
                MODE_XOR: begin
                    if (!pow2) begin
                        n_st = ST_XOR_SKIP;
                    end else begin
                        n_sp = r_own ^ r_step;
                        n_rp = r_own ^ r_step;
                    end
                end
                MODE_MIX: begin
                    n_sp = r_sa[RANK_W-1:0];
                    n_rp = r_ss[RANK_W-1:0];
                end
                default: begin
                    n_sp = lin_s[RANK_W-1:0];
                    n_rp = lin_r[RANK_W-1:0];
                end
            endcase
        end
    end

    // Configuration, table state, divider control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs        <= CFG_W'(1);
            r_own       <= '0;
            r_mode      <= MODE_XOR;
            r_ready_tab <= 1'b0;
            r_cnt       <= '0;
            r_dbusy     <= 1'b0;
            r_dcnt      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GROUP_SIZE: begin
                        r_gs        <= i_cfg_data;
                        r_ready_tab <= 1'b0;
                    end
                    REG_OWN_RANK:   r_own  <= i_cfg_data[RANK_W-1:0];
                    REG_SCHED_MODE: r_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_cmd.fact_init) begin
                r_cnt <= '0;
            end
            if (i_cmd.fact_push_d) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (i_cmd.fact_close) begin
                r_ready_tab <= 1'b1;
                if (r_fn > CFG_W'(1)) begin
                    r_cnt <= r_cnt + IDX_W'(1);
                end
            end
            if (i_cmd.fact_div || i_cmd.digit_div) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + IDX_W'(1);
                if (r_dcnt == IDX_W'(DIV_STEPS - 1)) begin
                    r_dbusy <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_step <= i_step_index;
        end
        if (i_cmd.fact_init) begin
            r_fn <= r_gs;
            r_fd <= CFG_W'(2);
        end
        if (i_cmd.fact_push_d) begin
            r_bases[r_cnt] <= r_fd;
            r_fn           <= r_dq_a;
        end
        if (i_cmd.fact_inc) begin
            r_fd <= fd_inc[CFG_W-1:0];
        end
        if (i_cmd.fact_close && (r_fn > CFG_W'(1))) begin
            r_bases[r_cnt] <= r_fn;
        end
        // Load or iterate the divider
        if (i_cmd.fact_div) begin
            r_dq_a <= r_fn;
            r_dr_a <= '0;
            r_dq_b <= '0;
            r_dr_b <= '0;
            r_dvs  <= r_fd;
        end else if (i_cmd.digit_div) begin
            r_dq_a <= r_tr;
            r_dr_a <= '0;
            r_dq_b <= r_ts;
            r_dr_b <= '0;
            r_dvs  <= r_bases[base_idx];
        end else if (r_dbusy) begin
            r_dr_a <= ge_a ? CFG_W'(t_a - dvs_x) : t_a[CFG_W-1:0];
            r_dq_a <= {r_dq_a[CFG_W-2:0], ge_a};
            r_dr_b <= ge_b ? CFG_W'(t_b - dvs_x) : t_b[CFG_W-1:0];
            r_dq_b <= {r_dq_b[CFG_W-2:0], ge_b};
        end
        // Digit walk
        if (i_cmd.digit_init) begin
            r_tr <= {1'b0, r_own};
            r_ts <= {1'b0, r_step};
            r_sa <= '0;
            r_ss <= '0;
            r_w  <= CFG_W'(1);
            r_k  <= '0;
        end
        if (i_cmd.digit_comb) begin
            r_pa <= prod_a[CFG_W-1:0];
            r_ps <= prod_s[CFG_W-1:0];
            r_tr <= r_dq_a;
            r_ts <= r_dq_b;
        end
        if (i_cmd.digit_acc) begin
            r_sa <= r_sa + r_pa;
            r_ss <= r_ss + r_ps;
            r_w  <= prod_w[CFG_W-1:0];
            r_k  <= r_k + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_sp <= n_sp;
            r_rp <= n_rp;
            r_st <= n_st;
        end
    end

    assign o_stat.range_err   = range_err;
    assign o_stat.mode_mix    = (r_mode == MODE_MIX);
    assign o_stat.bases_ready = r_ready_tab;
    assign o_stat.div_busy    = r_dbusy;
    assign o_stat.fn_le1      = (r_fn <= CFG_W'(1));
    assign o_stat.rem_zero    = (r_dr_a == '0);
    assign o_stat.sq_gt       = (sq > {{(CFG_W+2){1'b0}}, r_fn});
    assign o_stat.digits_done = (r_k == r_cnt);
    assign o_stat.out_busy    = r_ov && !i_ready;

    assign o_valid     = r_ov;
    assign o_dest_rank = r_sp;
    assign o_src_rank  = r_rp;
    assign o_status    = r_st;

endmodule

@@ sv/aps_ctrl.sv @@
// Controller state machine: sequences range check, factor table build,
// digit walk and output load. Depends on aps_pkg.
module aps_ctrl import aps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_EVAL   = 12'b0000_0000_0010,
        S_FINIT  = 12'b0000_0000_0100,
        S_FSTART = 12'b0000_0000_1000,
        S_FDIV   = 12'b0000_0001_0000,
        S_FRES   = 12'b0000_0010_0000,
        S_DINIT  = 12'b0000_0100_0000,
        S_DCHK   = 12'b0000_1000_0000,
        S_DDIV   = 12'b0001_0000_0000,
        S_DCOMB  = 12'b0010_0000_0000,
        S_DACC   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.range_err || !i_stat.mode_mix) begin
                    n_state = S_DONE;
                end else if (!i_stat.bases_ready) begin
                    n_state = S_FINIT;
                end else begin
                    n_state = S_DINIT;
                end
            end
            S_FINIT: begin
                o_cmd.fact_init = 1'b1;
                n_state = S_FSTART;
            end
            S_FSTART: begin
                if (i_stat.fn_le1) begin
                    o_cmd.fact_close = 1'b1;
                    n_state = S_DINIT;
                end else begin
                    o_cmd.fact_div = 1'b1;
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_FRES;
                end
            end
            S_FRES: begin
                if (i_stat.rem_zero) begin
                    o_cmd.fact_push_d = 1'b1;
                    n_state = S_FSTART;
                end else if (i_stat.sq_gt) begin
                    o_cmd.fact_close = 1'b1;
                    n_state = S_DINIT;
                end else begin
                    o_cmd.fact_inc = 1'b1;
                    n_state = S_FSTART;
                end
            end
            S_DINIT: begin
                o_cmd.digit_init = 1'b1;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                if (i_stat.digits_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.digit_div = 1'b1;
                    n_state = S_DDIV;
                end
            end
            S_DDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DCOMB;
                end
            end
            S_DCOMB: begin
                o_cmd.digit_comb = 1'b1;
                n_state = S_DACC;
            end
            S_DACC: begin
                o_cmd.digit_acc = 1'b1;
                n_state = S_DCHK;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ sv/alltoall_peer_schedule.sv @@
// Top level of the all-to-all peer schedule block.
// Instantiates aps_ctrl and aps_datapath; depends on aps_pkg.
//
//  channel   | handshake            | word
//  ----------+----------------------+------------------------------------
//  step in   | i_valid / o_ready    | i_step_index
//  peers out | o_valid / i_ready    | o_dest_rank, o_src_rank, o_status
//  config    | i_cfg_we             | i_cfg_index, i_cfg_data
//
// XOR, linear or range error: the controller goes from evaluate straight to done.
// Mixed radix: each digit base is divided out on the shared divider; the first
// word after a group size change also builds the factor table by trial division.
// Synchronous active-low reset; a held result does not block a new word.
module alltoall_peer_schedule import aps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RANK_W-1:0] i_step_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RANK_W-1:0] o_dest_rank,
    output logic [RANK_W-1:0] o_src_rank,
    output logic [1:0]        o_status,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    aps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    aps_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_step_index (i_step_index),
        .i_ready      (i_ready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_dest_rank  (o_dest_rank),
        .o_src_rank   (o_src_rank),
        .o_status     (o_status)
    );

endmodule

@@ sv/aps_checker.sv @@
// Port-level checks for alltoall_peer_schedule, bound to the top level.
// Depends on aps_pkg.
module aps_checker import aps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [RANK_W-1:0] o_dest_rank,
    input logic [RANK_W-1:0] o_src_rank,
    input logic [1:0]        o_status
);

    // Error words carry zero peers
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_dest_rank == '0 && o_src_rank == '0))
        else $error("error word with non-zero peer");

    // Drop ready after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after accept");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_dest_rank)
                                   && $stable(o_src_rank) && $stable(o_status)))
        else $error("stalled result changed");

    // Reset clears the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind alltoall_peer_schedule aps_checker u_aps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_dest_rank (o_dest_rank),
    .o_src_rank  (o_src_rank),
    .o_status    (o_status)
);

@@ bench/testbench.sv @@
// Self-checking bench for alltoall_peer_schedule: directed and random steps
// under every schedule mode, checked against an in-bench schedule predictor.
// Depends on aps_pkg and the RTL of the block only.
module testbench;
    import aps_pkg::*;

    // Spare mode code, handled as rotation
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [RANK_W-1:0] dest_rank;
        logic [RANK_W-1:0] src_rank;
        logic [1:0]        status;
    } t_peers;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [RANK_W-1:0] i_step_index = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [RANK_W-1:0] o_dest_rank;
    logic [RANK_W-1:0] o_src_rank;
    logic [1:0]        o_status;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = REG_GROUP_SIZE;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    // Predictor copy of the configuration and the factor table
    int unsigned group_now = 1;
    int unsigned rank_now = 0;
    logic [1:0]  mode_now = MODE_XOR;
    int unsigned radix_bases [MAX_DIGITS];
    int unsigned radix_count = 0;

    t_peers      peers_due [$];
    int          error_count = 0;
    int          burst_left = 0;
    int unsigned stall_cnt = 0;
    int          stall_style = 0;

    alltoall_peer_schedule dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Receiver stall pattern: always ready, coin toss, or one stall in eight
    always @(negedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 97 == 0) stall_style <= $urandom_range(0, 2);
        case (stall_style)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            default: i_ready <= (stall_cnt % 8) != 3;
        endcase
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (peers_due.size() == 0) begin
                $display("%0t: unexpected word dest=%0d src=%0d status=%0d",
                         $time, o_dest_rank, o_src_rank, o_status);
                error_count++;
            end else begin
                t_peers want;
                want = peers_due.pop_front();
                if (want.dest_rank !== o_dest_rank) begin
                    $display("%0t: dest_rank expected %0d actual %0d",
                             $time, want.dest_rank, o_dest_rank);
                    error_count++;
                end
                if (want.src_rank !== o_src_rank) begin
                    $display("%0t: src_rank expected %0d actual %0d",
                             $time, want.src_rank, o_src_rank);
                    error_count++;
                end
                if (want.status !== o_status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Factor the group size, largest prime first
    function automatic void factor_group(int unsigned n);
        int unsigned primes [16];
        int unsigned m, d, c;
        m = n;
        d = 2;
        c = 0;
        while (m > 1 && d * d <= m && c < 16) begin
            while (m % d == 0 && c < 16) begin
                primes[c] = d;
                c++;
                m = m / d;
            end
            d++;
        end
        if (m > 1 && c < 16) begin
            primes[c] = m;
            c++;
        end
        radix_count = (c > MAX_DIGITS) ? MAX_DIGITS : c;
        for (int i = 0; i < radix_count; i++) radix_bases[i] = primes[c - 1 - i] & 11'h7ff;
    endfunction

    // Digit-wise add or subtract of the step in the stored radix
    function automatic int unsigned radix_walk(int unsigned rank, int unsigned step,
                                               bit sub);
        int unsigned tr, ts, res, w, b, dr, ds;
        tr = rank;
        ts = step;
        res = 0;
        w = 1;
        for (int k = 0; k < radix_count; k++) begin
            b = (radix_bases[k] < 2) ? 2 : radix_bases[k];
            dr = tr % b;
            tr = tr / b;
            ds = ts % b;
            ts = ts / b;
            res += (sub ? (dr + b - ds) % b : (dr + ds) % b) * w;
            w = w * b;
        end
        return res;
    endfunction

    function automatic t_peers schedule_step(int unsigned step);
        t_peers p;
        int unsigned n;
        n = group_now;
        p = '0;
        if (n == 0 || n > MAX_RANKS || step >= n || rank_now >= n) begin
            p.status = ST_RANGE;
        end else if (mode_now == MODE_XOR) begin
            if ((n & (n - 1)) != 0) begin
                p.status = ST_XOR_SKIP;
            end else begin
                p.dest_rank = RANK_W'(rank_now ^ step);
                p.src_rank  = RANK_W'(rank_now ^ step);
            end
        end else if (mode_now == MODE_MIX) begin
            p.dest_rank = RANK_W'(radix_walk(rank_now, step, 1'b0));
            p.src_rank  = RANK_W'(radix_walk(rank_now, step, 1'b1));
        end else begin
            p.dest_rank = RANK_W'((rank_now + step) % n);
            p.src_rank  = RANK_W'((rank_now + n - step) % n);
        end
        return p;
    endfunction

    // Every task starts and ends at a falling edge
    task automatic send_step(int unsigned step);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_step_index <= step[RANK_W-1:0];
        do @(posedge i_clk); while (!o_ready);
        peers_due.push_back(schedule_step(step));
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted word has come back
    task automatic drain;
        i_valid <= 1'b0;
        burst_left = 0;
        while (peers_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_W-1:0];
        case (idx)
            REG_GROUP_SIZE: begin
                group_now = data & 11'h7ff;
                factor_group(group_now);
            end
            REG_OWN_RANK: rank_now = data & 10'h3ff;
            default: mode_now = data[1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(int unsigned group, int unsigned rank, logic [1:0] mode);
        drain();
        write_reg(REG_GROUP_SIZE, group);
        write_reg(REG_OWN_RANK, rank);
        write_reg(REG_SCHED_MODE, mode);
    endtask

    task automatic test_xor_pairing;
        configure(1024, 0, MODE_XOR);
        send_step(0);
        send_step(1023);
        configure(1024, 1023, MODE_XOR);
        send_step(512);
        send_step(341);
        // Size not a power of two is skipped
        configure(12, 3, MODE_XOR);
        send_step(5);
    endtask

    task automatic test_linear_rotation;
        configure(7, 6, MODE_LIN);
        send_step(0);
        send_step(6);
        send_step(3);
        // Unused mode code falls back to rotation
        configure(1000, 999, MODE_SPARE);
        send_step(998);
    endtask

    task automatic test_mixed_radix;
        configure(12, 5, MODE_MIX);
        send_step(0);
        send_step(7);
        send_step(11);
        configure(1021, 1020, MODE_MIX);
        send_step(1000);
        configure(1024, 1023, MODE_MIX);
        send_step(1023);
        send_step(1);
        // Group of one has no digits at all
        configure(1, 0, MODE_MIX);
        send_step(0);
    endtask

    task automatic test_range_errors;
        configure(0, 0, MODE_LIN);
        send_step(0);
        configure(2047, 0, MODE_MIX);
        send_step(5);
        configure(1025, 1, MODE_XOR);
        send_step(1);
        configure(16, 20, MODE_MIX);
        send_step(3);
        configure(16, 2, MODE_LIN);
        send_step(16);
        send_step(1023);
    endtask

    task automatic test_random_schedules;
        int unsigned g, r, s;
        logic [1:0] m;
        for (int ph = 0; ph < 35; ph++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: g = 1 << $urandom_range(0, 10);
                3: g = $urandom_range(0, 1) ? 1024 : 1;
                4: g = $urandom_range(0, 2047);
                default: g = $urandom_range(1, 1024);
            endcase
            r = ($urandom_range(0, 7) == 0 || g == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, g - 1);
            m = ($urandom_range(0, 9) == 0) ? MODE_SPARE : $urandom_range(0, 2);
            configure(g, r, m);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 9) == 0 || g == 0)
                    s = $urandom_range(0, 1023);
                else
                    s = $urandom_range(0, (g > 1024 ? 1024 : g) - 1);
                send_step(s);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_xor_pairing();
        test_linear_rotation();
        test_mixed_radix();
        test_range_errors();
        test_random_schedules();
        drain();
        repeat (50) @(negedge i_clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ alltoall_peer_schedule.f @@
sv/aps_pkg.sv
sv/aps_datapath.sv
sv/aps_ctrl.sv
sv/alltoall_peer_schedule.sv
sv/aps_checker.sv
bench/testbench.sv
